// ===== sv/rfs_pkg.sv =====
`timescale 1ns / 1ps

package rfs_pkg;

    localparam int ChanNum  = 3;
    localparam int RamDepth = 8;
    localparam int RamAw    = $clog2(RamDepth);

    typedef enum logic [2:0] {
        CFG_START    = 3'd0,
        CFG_END      = 3'd1,
        CFG_FADE_IN  = 3'd2,
        CFG_FADE_OUT = 3'd3,
        CFG_HOLD     = 3'd4,
        CFG_REPEAT   = 3'd5,
        CFG_KEEP     = 3'd6,
        STATE_SLOT   = 3'd7
    } t_slot;

    typedef enum logic [2:0] {
        PH_FADE_IN  = 3'd0,
        PH_HOLD_HI  = 3'd1,
        PH_FADE_OUT = 3'd2,
        PH_HOLD_LO  = 3'd3,
        PH_DONE     = 3'd4
    } t_phase;

    typedef enum logic [1:0] {
        SRC_PREV,
        SRC_INTERP,
        SRC_END,
        SRC_START
    } t_src;

    typedef struct packed {
        t_phase      phase;
        logic [9:0]  fade_index;
        logic        fade_fresh;
        logic [7:0]  hold_count;
        logic [15:0] cycle_count;
        logic [2:0]  end_countdown;
        logic [23:0] shown_color;
        logic [15:0] last_delay;
    } t_seq_state;

    typedef struct packed {
        logic tick;
    } t_tick_item;

    typedef struct packed {
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [15:0] delay_ms;
        logic        active;
    } t_frame_item;

    localparam int WordW = $bits(t_seq_state);

    localparam logic [23:0] StartColorRst = 24'hFFAE0B;
    localparam logic [23:0] HoldTimingRst = 24'd12;
    localparam logic [15:0] FinishDelay   = 16'd100;

    localparam t_seq_state StateRst = '{
        phase:         PH_FADE_IN,
        fade_index:    10'd0,
        fade_fresh:    1'b1,
        hold_count:    8'd0,
        cycle_count:   16'd1,
        end_countdown: 3'd5,
        shown_color:   24'd0,
        last_delay:    16'd0
    };

    function automatic logic [WordW-1:0] slot_reset(t_slot s);
        logic [WordW-1:0] w;
        w = '0;
        unique case (s)
            CFG_START:  w = WordW'(StartColorRst);
            CFG_HOLD:   w = WordW'(HoldTimingRst);
            CFG_KEEP:   w = WordW'(1'b1);
            STATE_SLOT: w = StateRst;
            default:    w = '0;
        endcase
        return w;
    endfunction

endpackage

// ===== sv/rfs_chan_if.sv =====
`timescale 1ns / 1ps

interface rfs_chan_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== sv/rfs_ram.sv =====
`timescale 1ns / 1ps

module rfs_ram #(
    parameter int W = 8,
    parameter int D = 8
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);

    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/rfs_interp.sv =====
`timescale 1ns / 1ps

module rfs_interp import rfs_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_go,
    input  logic [23:0] i_start_color,
    input  logic [23:0] i_end_color,
    input  logic [7:0]  i_idx,
    input  logic [7:0]  i_steps,
    output logic        o_done,
    output logic [23:0] o_color
);

    localparam int NumW = 17;

    logic [NumW-1:0] r_rem [ChanNum];
    logic [NumW-1:0] n_rem [ChanNum];
    logic [NumW-1:0] num   [ChanNum];
    logic [7:0]      r_quo [ChanNum];
    logic [7:0]      n_quo [ChanNum];
    logic [NumW-1:0] r_dsh;
    logic [2:0]      r_cnt;
    logic            r_busy;
    logic            r_done;

    always_comb begin
        logic [15:0] prod_s;
        logic [15:0] prod_e;
        for (int k = 0; k < ChanNum; k++) begin
            prod_s = 16'(i_start_color[8*k +: 8]) * 16'(i_steps - i_idx);
            prod_e = 16'(i_end_color[8*k +: 8]) * 16'(i_idx);
            num[k] = {prod_s + prod_e, 1'b0} + NumW'(i_steps);
            if (r_rem[k] >= r_dsh) begin
                n_rem[k] = r_rem[k] - r_dsh;
                n_quo[k] = {r_quo[k][6:0], 1'b1};
            end else begin
                n_rem[k] = r_rem[k];
                n_quo[k] = {r_quo[k][6:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (r_busy) begin
                r_cnt <= r_cnt + 3'd1;
                if (r_cnt == 3'd7) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end else if (i_go) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_dsh <= r_dsh >> 1;
            for (int k = 0; k < ChanNum; k++) begin
                r_rem[k] <= n_rem[k];
                r_quo[k] <= n_quo[k];
            end
        end else if (i_go) begin
            r_dsh <= {1'b0, i_steps, 8'h00};
            for (int k = 0; k < ChanNum; k++) begin
                r_rem[k] <= num[k];
                r_quo[k] <= '0;
            end
        end
    end

    assign o_done  = r_done;
    assign o_color = {r_quo[2], r_quo[1], r_quo[0]};

endmodule

// ===== sv/rgb_fade_sequencer.sv =====
`timescale 1ns / 1ps
// A tick is accepted only in the idle state, after the previous result has been
// handed on; a fade color is interpolated by the eight-step divider.
// A result waiting in the output register does not block the next input
// transfer.
// Reset: control state clears at once; memory entries read back their reset
// values until first written, so no clearing pass is needed.
module rgb_fade_sequencer import rfs_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    rfs_chan_if.sink          i_tick_ch,
    rfs_chan_if.source        o_frame_ch,
    input  logic              i_cfg_we,
    input  logic [RamAw-1:0]  i_cfg_idx,
    input  logic [23:0]       i_cfg_wdata
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_STEPS,
        S_CTRL,
        S_INTERP,
        S_WB,
        S_OUT
    } t_fsm;

    t_fsm            r_state;
    logic [RamAw:0]  r_cnt;
    logic [RamDepth-1:0] r_valid;
    logic            r_rd_valid;
    t_slot           r_rd_slot;
    logic            r_tick;
    logic [23:0]     r_start;
    logic [23:0]     r_end;
    logic [23:0]     r_fin;
    logic [23:0]     r_fout;
    logic [23:0]     r_hold;
    logic [15:0]     r_rep;
    logic            r_keep;
    t_seq_state      r_st;
    t_seq_state      r_nx;
    t_src            r_src;
    logic [7:0]      r_iidx;
    logic            r_act;
    logic [7:0]      r_steps;
    logic            r_go;
    logic [23:0]     r_icolor;
    t_frame_item     r_res;
    t_frame_item     r_out;
    logic            r_out_valid;

    t_seq_state      n_nx;
    t_src            n_src;
    logic [7:0]      n_iidx;
    logic            n_act;
    logic [7:0]      n_steps;
    logic [23:0]     wb_color;
    t_seq_state      wb_state;

    logic            ram_we;
    logic [RamAw-1:0] ram_waddr;
    logic [WordW-1:0] ram_wdata;
    logic [RamAw-1:0] ram_raddr;
    logic [WordW-1:0] ram_rdata;
    logic [WordW-1:0] rd_word;
    logic [23:0]     cfg_data;
    logic            cfg_hit;
    logic            interp_done;
    logic [23:0]     interp_color;

    // Memory port: configuration writes, state write-back, sequential reads
    always_comb begin
        cfg_hit = i_cfg_we && (i_cfg_idx <= CFG_KEEP);
        unique case (t_slot'(i_cfg_idx))
            CFG_REPEAT: cfg_data = {8'h00, i_cfg_wdata[15:0]};
            CFG_KEEP:   cfg_data = {23'h0, i_cfg_wdata[0]};
            default:    cfg_data = i_cfg_wdata;
        endcase
        ram_we    = cfg_hit || (r_state == S_WB);
        ram_waddr = (r_state == S_WB) ? RamAw'(STATE_SLOT) : i_cfg_idx;
        ram_wdata = (r_state == S_WB) ? WordW'(wb_state) : WordW'(cfg_data);
        ram_raddr = r_cnt[RamAw-1:0];
        rd_word   = r_rd_valid ? ram_rdata : slot_reset(r_rd_slot);
    end

    rfs_ram #(
        .W (WordW),
        .D (RamDepth)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    rfs_interp u_interp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_go          (r_go),
        .i_start_color (r_start),
        .i_end_color   (r_end),
        .i_idx         (r_iidx),
        .i_steps       (r_steps),
        .o_done        (interp_done),
        .o_color       (interp_color)
    );

    // Largest channel span, zero taken as one
    always_comb begin
        logic [7:0] a;
        logic [7:0] b;
        logic [7:0] d;
        logic [7:0] m;
        m = '0;
        for (int k = 0; k < ChanNum; k++) begin
            a = r_end[8*k +: 8];
            b = r_start[8*k +: 8];
            d = (a >= b) ? a - b : b - a;
            if (d > m) begin
                m = d;
            end
        end
        n_steps = (m == '0) ? 8'd1 : m;
    end

    // Phase walk for one tick
    always_comb begin
        logic shown;
        n_nx   = r_st;
        n_src  = SRC_PREV;
        n_iidx = '0;
        n_act  = 1'b1;
        shown  = 1'b0;
        if (!r_tick) begin
            n_act = !(r_st.phase == PH_DONE && r_st.end_countdown == '0 && !r_keep);
        end else begin
            if (n_nx.phase == PH_FADE_IN) begin
                shown = 1'b0;
                if (r_fin[23:16] != '0) begin
                    if (n_nx.fade_fresh) begin
                        n_nx.fade_fresh = 1'b0;
                        n_nx.fade_index = '0;
                        n_src  = SRC_INTERP;
                        n_iidx = '0;
                        shown  = 1'b1;
                    end else if (n_nx.fade_index <= 10'(r_steps)) begin
                        n_src  = SRC_INTERP;
                        n_iidx = n_nx.fade_index[7:0];
                        n_nx.fade_index = n_nx.fade_index + 10'(r_fin[23:16]);
                        shown  = 1'b1;
                    end
                end
                if (shown) begin
                    n_nx.last_delay = r_fin[15:0];
                end else begin
                    n_nx.phase      = PH_HOLD_HI;
                    n_nx.fade_fresh = 1'b1;
                    n_nx.fade_index = '0;
                end
            end
            if (n_nx.phase == PH_HOLD_HI) begin
                if (n_nx.hold_count < r_hold[23:16]) begin
                    n_src = SRC_END;
                    n_nx.last_delay = {8'h00, r_hold[7:0]};
                    n_nx.hold_count = n_nx.hold_count + 8'd1;
                end else begin
                    n_nx.phase      = PH_FADE_OUT;
                    n_nx.hold_count = '0;
                end
            end
            if (n_nx.phase == PH_FADE_OUT) begin
                shown = 1'b0;
                if (r_fout[23:16] != '0) begin
                    if (n_nx.fade_fresh) begin
                        n_nx.fade_fresh = 1'b0;
                        n_nx.fade_index = '0;
                        n_src  = SRC_INTERP;
                        n_iidx = r_steps;
                        shown  = 1'b1;
                    end else if (n_nx.fade_index <= 10'(r_steps)) begin
                        n_src  = SRC_INTERP;
                        n_iidx = r_steps - n_nx.fade_index[7:0];
                        n_nx.fade_index = n_nx.fade_index + 10'(r_fout[23:16]);
                        shown  = 1'b1;
                    end
                end
                if (shown) begin
                    n_nx.last_delay = r_fout[15:0];
                end else begin
                    n_nx.phase      = PH_HOLD_LO;
                    n_nx.fade_fresh = 1'b1;
                    n_nx.fade_index = '0;
                end
            end
            if (n_nx.phase == PH_HOLD_LO) begin
                if (n_nx.hold_count < r_hold[15:8]) begin
                    n_src = SRC_START;
                    n_nx.last_delay = {8'h00, r_hold[7:0]};
                    n_nx.hold_count = n_nx.hold_count + 8'd1;
                end else begin
                    n_nx.hold_count = '0;
                    n_nx.fade_fresh = 1'b1;
                    n_nx.fade_index = '0;
                    if (r_rep != '0 && n_nx.cycle_count >= r_rep) begin
                        n_nx.phase = PH_DONE;
                    end else begin
                        if (n_nx.cycle_count != 16'hFFFF) begin
                            n_nx.cycle_count = n_nx.cycle_count + 16'd1;
                        end
                        n_nx.phase = PH_FADE_IN;
                    end
                end
            end
            if (n_nx.phase == PH_DONE) begin
                if (n_nx.end_countdown != '0 || r_keep) begin
                    n_nx.last_delay = FinishDelay;
                end else begin
                    n_act = 1'b0;
                end
                if (n_nx.end_countdown != '0) begin
                    n_nx.end_countdown = n_nx.end_countdown - 3'd1;
                end
            end
        end
    end

    always_comb begin
        case (r_src)
            SRC_INTERP: wb_color = r_icolor;
            SRC_END:    wb_color = r_end;
            SRC_START:  wb_color = r_start;
            default:    wb_color = r_nx.shown_color;
        endcase
        wb_state             = r_nx;
        wb_state.shown_color = wb_color;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_valid     <= '0;
            r_rd_valid  <= 1'b0;
            r_rd_slot   <= CFG_START;
            r_go        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_go <= 1'b0;
            if (ram_we) begin
                r_valid[ram_waddr] <= 1'b1;
            end
            if (o_frame_ch.ready && r_state != S_OUT) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    r_cnt <= '0;
                    if (i_tick_ch.valid) begin
                        r_state <= S_READ;
                    end
                end
                S_READ: begin
                    r_rd_valid <= r_valid[ram_raddr];
                    r_rd_slot  <= t_slot'(ram_raddr);
                    r_cnt      <= r_cnt + (RamAw+1)'(1);
                    if (r_cnt == (RamAw+1)'(RamDepth)) begin
                        r_state <= S_STEPS;
                    end
                end
                S_STEPS: begin
                    r_state <= S_CTRL;
                end
                S_CTRL: begin
                    if (n_src == SRC_INTERP) begin
                        r_go    <= 1'b1;
                        r_state <= S_INTERP;
                    end else begin
                        r_state <= S_WB;
                    end
                end
                S_INTERP: begin
                    if (interp_done) begin
                        r_state <= S_WB;
                    end
                end
                S_WB: begin
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!r_out_valid || o_frame_ch.ready) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_tick_ch.valid) begin
            r_tick <= i_tick_ch.data.tick;
        end
        if (r_state == S_READ && r_cnt != '0) begin
            case (r_rd_slot)
                CFG_START:    r_start <= rd_word[23:0];
                CFG_END:      r_end   <= rd_word[23:0];
                CFG_FADE_IN:  r_fin   <= rd_word[23:0];
                CFG_FADE_OUT: r_fout  <= rd_word[23:0];
                CFG_HOLD:     r_hold  <= rd_word[23:0];
                CFG_REPEAT:   r_rep   <= rd_word[15:0];
                CFG_KEEP:     r_keep  <= rd_word[0];
                default:      r_st    <= t_seq_state'(rd_word);
            endcase
        end
        if (r_state == S_STEPS) begin
            r_steps <= n_steps;
        end
        if (r_state == S_CTRL) begin
            r_nx   <= n_nx;
            r_src  <= n_src;
            r_iidx <= n_iidx;
            r_act  <= n_act;
        end
        if (r_state == S_INTERP && interp_done) begin
            r_icolor <= interp_color;
        end
        if (r_state == S_WB) begin
            r_res.red      <= r_act ? wb_color[23:16] : 8'h00;
            r_res.green    <= r_act ? wb_color[15:8] : 8'h00;
            r_res.blue     <= r_act ? wb_color[7:0] : 8'h00;
            r_res.delay_ms <= r_act ? r_nx.last_delay : 16'h0000;
            r_res.active   <= r_act;
        end
        if (r_state == S_OUT && (!r_out_valid || o_frame_ch.ready)) begin
            r_out <= r_res;
        end
    end

    assign i_tick_ch.ready  = (r_state == S_IDLE);
    assign o_frame_ch.valid = r_out_valid;
    assign o_frame_ch.data  = r_out;

endmodule

// ===== tb/sv/rgb_fade_sequencer_tb.sv =====
`timescale 1ns / 1ps

module rgb_fade_sequencer_tb;
    import rfs_pkg::*;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_cfg_we = 1'b0;
    logic [RamAw-1:0]  i_cfg_idx = '0;
    logic [23:0]       i_cfg_wdata = '0;

    rfs_chan_if #(.T(t_tick_item))  tick_ch ();
    rfs_chan_if #(.T(t_frame_item)) frame_ch ();

    rgb_fade_sequencer dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tick_ch   (tick_ch),
        .o_frame_ch  (frame_ch),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always #6 i_clk = ~i_clk;

    logic [23:0] cfg_start_color;
    logic [23:0] cfg_end_color;
    logic [23:0] cfg_fade_in;
    logic [23:0] cfg_fade_out;
    logic [23:0] cfg_hold;
    logic [15:0] cfg_repeat;
    logic        cfg_keep_end;
    t_seq_state  seq;

    t_tick_item  pending_ticks[$];
    t_frame_item frames_due[$];
    int          ticks_queued = 0;
    int          frames_seen = 0;
    int          mismatches = 0;
    int          inactive_seen = 0;
    int          settings_used = 0;
    logic        idle_on = 1'b1;
    int          gap_left;
    int          stall_left;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 24);
        return $urandom_range(40, 150);
    endfunction

    function automatic logic [23:0] pick_timing();
        int          r;
        logic [7:0]  step_by;
        logic [15:0] wait_ms;
        r = $urandom_range(0, 99);
        if (r < 20) step_by = 8'd0;
        else if (r < 75) step_by = 8'($urandom_range(1, 20));
        else if (r < 90) step_by = 8'($urandom_range(21, 254));
        else step_by = 8'hFF;
        r = $urandom_range(0, 9);
        wait_ms = (r == 0) ? 16'h0000 : (r == 1) ? 16'hFFFF : 16'($urandom);
        return {step_by, wait_ms};
    endfunction

    function automatic int fade_span();
        int m;
        int d;
        m = 0;
        for (int k = 0; k < ChanNum; k++) begin
            d = int'(cfg_end_color[8*k +: 8]) - int'(cfg_start_color[8*k +: 8]);
            if (d < 0) d = -d;
            if (d > m) m = d;
        end
        return (m == 0) ? 1 : m;
    endfunction

    function automatic logic [23:0] blend_color(int idx, int steps);
        logic [23:0] mix;
        int          s, d, num, den, q, v;
        mix = '0;
        for (int k = 0; k < ChanNum; k++) begin
            s = int'(cfg_start_color[8*k +: 8]);
            d = int'(cfg_end_color[8*k +: 8]) - s;
            num = 2 * d * idx + steps;
            den = 2 * steps;
            q = num / den;
            if (num % den != 0 && num < 0) q = q - 1;
            v = s + q;
            if (v < 0) v = 0;
            if (v > 255) v = 255;
            mix[8*k +: 8] = v[7:0];
        end
        return mix;
    endfunction

    function automatic t_frame_item advance_frame(logic tick);
        t_frame_item f;
        int          steps;
        int          step_by;
        logic [23:0] color;
        logic [15:0] wait_ms;
        logic        act;
        logic        shown;
        steps = fade_span();
        color = seq.shown_color;
        wait_ms = seq.last_delay;
        act = 1'b1;
        if (!tick) begin
            act = !(seq.phase == PH_DONE && seq.end_countdown == 0 && !cfg_keep_end);
        end else begin
            if (seq.phase == PH_FADE_IN) begin
                step_by = int'(cfg_fade_in[23:16]);
                shown = 1'b0;
                if (step_by != 0) begin
                    if (seq.fade_fresh) begin
                        seq.fade_fresh = 1'b0;
                        seq.fade_index = '0;
                        color = blend_color(0, steps);
                        shown = 1'b1;
                    end else if (int'(seq.fade_index) <= steps) begin
                        color = blend_color(int'(seq.fade_index), steps);
                        seq.fade_index = seq.fade_index + 10'(step_by);
                        shown = 1'b1;
                    end
                end
                if (shown) begin
                    wait_ms = cfg_fade_in[15:0];
                end else begin
                    seq.phase = PH_HOLD_HI;
                    seq.fade_fresh = 1'b1;
                    seq.fade_index = '0;
                end
            end
            if (seq.phase == PH_HOLD_HI) begin
                if (seq.hold_count < cfg_hold[23:16]) begin
                    color = cfg_end_color;
                    wait_ms = {8'h00, cfg_hold[7:0]};
                    seq.hold_count = seq.hold_count + 8'd1;
                end else begin
                    seq.phase = PH_FADE_OUT;
                    seq.hold_count = '0;
                end
            end
            if (seq.phase == PH_FADE_OUT) begin
                step_by = int'(cfg_fade_out[23:16]);
                shown = 1'b0;
                if (step_by != 0) begin
                    if (seq.fade_fresh) begin
                        seq.fade_fresh = 1'b0;
                        seq.fade_index = '0;
                        color = blend_color(steps, steps);
                        shown = 1'b1;
                    end else if (int'(seq.fade_index) <= steps) begin
                        color = blend_color(steps - int'(seq.fade_index), steps);
                        seq.fade_index = seq.fade_index + 10'(step_by);
                        shown = 1'b1;
                    end
                end
                if (shown) begin
                    wait_ms = cfg_fade_out[15:0];
                end else begin
                    seq.phase = PH_HOLD_LO;
                    seq.fade_fresh = 1'b1;
                    seq.fade_index = '0;
                end
            end
            if (seq.phase == PH_HOLD_LO) begin
                if (seq.hold_count < cfg_hold[15:8]) begin
                    color = cfg_start_color;
                    wait_ms = {8'h00, cfg_hold[7:0]};
                    seq.hold_count = seq.hold_count + 8'd1;
                end else begin
                    seq.hold_count = '0;
                    seq.fade_fresh = 1'b1;
                    seq.fade_index = '0;
                    if (cfg_repeat != 0 && seq.cycle_count >= cfg_repeat) begin
                        seq.phase = PH_DONE;
                    end else begin
                        if (seq.cycle_count != 16'hFFFF) seq.cycle_count = seq.cycle_count + 16'd1;
                        seq.phase = PH_FADE_IN;
                    end
                end
            end
            if (seq.phase == PH_DONE) begin
                if (seq.end_countdown != 0 || cfg_keep_end) wait_ms = FinishDelay;
                else act = 1'b0;
                if (seq.end_countdown != 0) seq.end_countdown = seq.end_countdown - 3'd1;
            end
            seq.shown_color = color;
            seq.last_delay = wait_ms;
        end
        if (!act) begin
            color = '0;
            wait_ms = '0;
        end
        f.red = color[23:16];
        f.green = color[15:8];
        f.blue = color[7:0];
        f.delay_ms = wait_ms;
        f.active = act;
        return f;
    endfunction

    task automatic send_tick(logic b);
        t_tick_item it;
        it.tick = b;
        pending_ticks = {pending_ticks, it};
        ticks_queued++;
    endtask

    task automatic drain();
        while (frames_seen != ticks_queued) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
    endtask

    task automatic set_reg(t_slot slot, logic [23:0] value);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= slot;
        i_cfg_wdata <= value;
        case (slot)
            CFG_START:    cfg_start_color = value;
            CFG_END:      cfg_end_color = value;
            CFG_FADE_IN:  cfg_fade_in = value;
            CFG_FADE_OUT: cfg_fade_out = value;
            CFG_HOLD:     cfg_hold = value;
            CFG_REPEAT:   cfg_repeat = value[15:0];
            CFG_KEEP:     cfg_keep_end = value[0];
            default:      ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            tick_ch.valid <= 1'b0;
            gap_left <= 0;
        end else if (!tick_ch.valid || tick_ch.ready) begin
            if (gap_left != 0) begin
                tick_ch.valid <= 1'b0;
                gap_left <= gap_left - 1;
            end else if (pending_ticks.size() != 0) begin
                tick_ch.valid <= 1'b1;
                tick_ch.data <= pending_ticks.pop_front();
                gap_left <= idle_on ? pick_gap() : 0;
            end else begin
                tick_ch.valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            frame_ch.ready <= 1'b0;
            stall_left <= 0;
        end else if (stall_left != 0) begin
            frame_ch.ready <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            frame_ch.ready <= 1'b1;
            stall_left <= idle_on ? pick_gap() : 0;
        end
    end

    always @(posedge i_clk) begin
        t_frame_item want;
        if (i_rst_n) begin
            if (frame_ch.valid && frame_ch.ready) begin
                frames_seen++;
                if (!frame_ch.data.active) inactive_seen++;
                if (frames_due.size() == 0) begin
                    $error("frame transfer with no frame pending");
                    mismatches++;
                end else begin
                    want = frames_due.pop_front();
                    if (frame_ch.data.red !== want.red) begin
                        $error("red: expected %0d, got %0d", want.red, frame_ch.data.red);
                        mismatches++;
                    end
                    if (frame_ch.data.green !== want.green) begin
                        $error("green: expected %0d, got %0d", want.green, frame_ch.data.green);
                        mismatches++;
                    end
                    if (frame_ch.data.blue !== want.blue) begin
                        $error("blue: expected %0d, got %0d", want.blue, frame_ch.data.blue);
                        mismatches++;
                    end
                    if (frame_ch.data.delay_ms !== want.delay_ms) begin
                        $error("delay_ms: expected %0d, got %0d", want.delay_ms,
                               frame_ch.data.delay_ms);
                        mismatches++;
                    end
                    if (frame_ch.data.active !== want.active) begin
                        $error("active: expected %0d, got %0d", want.active,
                               frame_ch.data.active);
                        mismatches++;
                    end
                end
            end
            if (tick_ch.valid && tick_ch.ready) begin
                frames_due = {frames_due, advance_frame(tick_ch.data.tick)};
            end
        end
    end

    initial begin
        #20_000_000;
        $display("Some tests failed");
        $finish;
    end

    initial begin
        int          n;
        int          pct;
        int          v;
        logic [23:0] col;
        cfg_start_color = StartColorRst;
        cfg_end_color = '0;
        cfg_fade_in = '0;
        cfg_fade_out = '0;
        cfg_hold = HoldTimingRst;
        cfg_repeat = '0;
        cfg_keep_end = 1'b1;
        seq = StateRst;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: every tick wraps straight to a new cycle
        send_tick(1'b1);
        send_tick(1'b0);
        send_tick(1'b1);
        drain();

        // full-range fade, stop partway through the fade-out
        set_reg(CFG_START, 24'h000000);
        set_reg(CFG_END, 24'hFFFFFF);
        set_reg(CFG_FADE_IN, {8'hFF, 16'hFFFF});
        set_reg(CFG_FADE_OUT, {8'h80, 16'h0000});
        set_reg(CFG_HOLD, {8'd2, 8'd1, 8'hFF});
        set_reg(CFG_REPEAT, 16'hFFFF);
        set_reg(CFG_KEEP, 24'd0);
        settings_used++;
        for (int k = 0; k < 9; k++) send_tick(k != 2 && k != 6);
        drain();

        // shrink the span mid fade-out so the index is past the end
        set_reg(CFG_START, 24'h102030);
        set_reg(CFG_END, 24'h102031);
        set_reg(CFG_FADE_IN, {8'd1, 16'd5});
        set_reg(CFG_FADE_OUT, 24'd0);
        set_reg(CFG_HOLD, {8'd0, 8'd0, 8'd7});
        settings_used++;
        for (int k = 0; k < 7; k++) send_tick(k != 4);
        drain();

        for (int ph = 0; ph < 22; ph++) begin
            idle_on = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 3) != 0) begin
                v = $urandom_range(0, 9);
                col = (v == 0) ? 24'h000000 : (v == 1) ? 24'hFFFFFF : 24'($urandom);
                set_reg(CFG_START, col);
            end
            if ($urandom_range(0, 3) != 0) begin
                v = $urandom_range(0, 99);
                if (v < 15) begin
                    col = 24'($urandom);
                end else if (v < 25) begin
                    col = (v < 20) ? 24'h000000 : 24'hFFFFFF;
                end else begin
                    for (int k = 0; k < ChanNum; k++) begin
                        n = int'(cfg_start_color[8*k +: 8]) + $urandom_range(0, 24) - 12;
                        if (n < 0) n = 0;
                        if (n > 255) n = 255;
                        col[8*k +: 8] = n[7:0];
                    end
                end
                set_reg(CFG_END, col);
            end
            if ($urandom_range(0, 3) != 0) set_reg(CFG_FADE_IN, pick_timing());
            if ($urandom_range(0, 3) != 0) set_reg(CFG_FADE_OUT, pick_timing());
            if ($urandom_range(0, 3) != 0) begin
                col[23:16] = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(5, 40))
                                                          : 8'($urandom_range(0, 4));
                col[15:8] = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(5, 40))
                                                         : 8'($urandom_range(0, 4));
                col[7:0] = 8'($urandom);
                set_reg(CFG_HOLD, col);
            end
            if ($urandom_range(0, 3) != 0) begin
                v = $urandom_range(0, 9);
                if (v < 5) set_reg(CFG_REPEAT, 24'd0);
                else if (v < 7) set_reg(CFG_REPEAT, 24'hFFFF);
                else set_reg(CFG_REPEAT, 24'($urandom_range(5000, 65534)));
            end
            if ($urandom_range(0, 3) != 0) set_reg(CFG_KEEP, 24'($urandom_range(0, 1)));
            settings_used++;
            n = $urandom_range(40, 70);
            pct = $urandom_range(70, 97);
            for (int k = 0; k < n; k++) begin
                // hold off until every pending frame is back
                if (ph == 11 && k == n / 2) drain();
                send_tick($urandom_range(0, 99) < pct);
            end
            drain();
        end

        // short cycle that finishes, then toggle keep-end on the final color
        idle_on = 1'b1;
        set_reg(CFG_FADE_IN, {8'd64, 16'd40});
        set_reg(CFG_FADE_OUT, {8'd64, 16'd41});
        set_reg(CFG_HOLD, {8'd1, 8'd1, 8'd9});
        set_reg(CFG_KEEP, 24'd0);
        set_reg(CFG_REPEAT, 24'd1);
        settings_used++;
        for (int k = 0; k < 40; k++) send_tick($urandom_range(0, 99) < 90);
        drain();
        set_reg(CFG_KEEP, 24'd1);
        settings_used++;
        for (int k = 0; k < 15; k++) send_tick($urandom_range(0, 99) < 80);
        drain();
        set_reg(CFG_KEEP, 24'd0);
        settings_used++;
        for (int k = 0; k < 15; k++) send_tick($urandom_range(0, 99) < 80);
        drain();

        if (frames_due.size() != 0) begin
            $error("%0d frames never arrived", frames_due.size());
            mismatches++;
        end
        $display("Checked %0d frames over %0d register settings, %0d after the animation ended",
                 frames_seen, settings_used, inactive_seen);
        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
